// ----- rtl/bfa_pkg.sv -----
// Package for the first-free bitmap allocator: map geometry, command codes,
// controller states and the structs passed between the controller, memory and top.
// No dependencies.
package bfa_pkg;

  // Map geometry
  localparam int MAP_BLOCKS      = 8;
  localparam int BLOCK_BYTES     = 1024;
  localparam int MAP_BYTES       = MAP_BLOCKS * BLOCK_BYTES;
  localparam int WORD_BYTES      = 8;
  localparam int WORD_BITS       = WORD_BYTES * 8;
  localparam int MAP_WORDS       = MAP_BYTES / WORD_BYTES;
  localparam int WORDS_PER_BLOCK = BLOCK_BYTES / WORD_BYTES;
  localparam int WORD_AW         = $clog2(MAP_WORDS);
  localparam int LIMIT_W         = $clog2(MAP_WORDS + 1);
  localparam int BLK_W           = $clog2(MAP_BLOCKS + 1);
  localparam int LANE_W          = $clog2(WORD_BYTES);
  localparam int POS_W           = $clog2(WORD_BITS);

  // Field widths
  localparam int CMD_W   = 2;
  localparam int BIDX_W  = 13;
  localparam int BYTE_W  = 8;
  localparam int AIDX_W  = 16;
  localparam int CFG_W   = 4;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCAN,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic                  en;
    logic [WORD_AW-1:0]    addr;
    logic [WORD_BYTES-1:0] be;
    logic [WORD_BITS-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] read_byte;
    logic [AIDX_W-1:0] allocated_index;
    logic              map_full;
  } result_t;

endpackage

// ----- rtl/bfa_map_mem.sv -----
// Bitmap store: one-write, one-read synchronous memory of 64-bit words with byte enables.
// Read data is registered. Depends on bfa_pkg.
module bfa_map_mem
  import bfa_pkg::*;
(
  input  logic                 clk,
  input  mem_wr_t              wr,
  input  mem_rd_t              rd,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int i = 0; i < WORD_BYTES; i++) begin
        if (wr.be[i]) begin
          mem[wr.addr][i*8 +: 8] <= wr.data[i*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/bfa_ctrl.sv -----
// Command sequencer: byte write/read and the first-fit scan with read-modify-write.
// Drives the bitmap memory ports and hands one result per command to the top.
// Depends on bfa_pkg.
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [BIDX_W-1:0]    in_byte_index,
  input  logic [BYTE_W-1:0]    in_byte_value,
  input  logic [CFG_W-1:0]     blocks_in_use,
  output mem_wr_t              mem_wr,
  output mem_rd_t              mem_rd,
  input  logic [WORD_BITS-1:0] rd_data,
  input  logic                 out_free,
  output result_t              res
);

  ctrl_state_t          state_r, state_nxt;
  logic                 addr_ok_r, addr_ok_nxt;
  logic [LANE_W-1:0]    lane_r, lane_nxt;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [LIMIT_W-1:0]   issue_ptr_r, issue_ptr_nxt;
  logic [WORD_AW-1:0]   chk_ptr_r, chk_ptr_nxt;
  logic                 chk_valid_r, chk_valid_nxt;
  logic [BYTE_W-1:0]    rd_byte_r, rd_byte_nxt;
  logic [AIDX_W-1:0]    aidx_r, aidx_nxt;
  logic                 full_r, full_nxt;

  logic                 accept;
  logic                 addr_ok_in;
  logic [WORD_AW-1:0]   word_in;
  logic [LANE_W-1:0]    lane_in;
  logic [BLK_W-1:0]     blocks_sat;
  logic [LIMIT_W-1:0]   limit_in;
  logic                 hit;
  logic                 last;
  logic                 issue;
  logic [POS_W-1:0]     pos;

  // Lowest clear bit of the word under test: lowest byte first, lowest bit first.
  function automatic logic [POS_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

  assign accept     = in_valid && in_ready;
  assign addr_ok_in = (int'(in_byte_index) < MAP_BYTES);
  assign word_in    = WORD_AW'(in_byte_index >> LANE_W);
  assign lane_in    = in_byte_index[LANE_W-1:0];

  always_comb begin
    if (int'(blocks_in_use) > MAP_BLOCKS) begin
      blocks_sat = BLK_W'(MAP_BLOCKS);
    end else begin
      blocks_sat = BLK_W'(blocks_in_use);
    end
    limit_in = LIMIT_W'(int'(blocks_sat) * WORDS_PER_BLOCK);
  end

  assign hit   = chk_valid_r && (rd_data != {WORD_BITS{1'b1}});
  assign last  = chk_valid_r && !hit &&
                 ((LIMIT_W'(chk_ptr_r) + LIMIT_W'(1)) == limit_r);
  assign issue = (state_r == ST_SCAN) && !hit && (issue_ptr_r < limit_r);
  assign pos   = first_zero(rd_data);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_READ:  state_nxt = ST_RD_WAIT;
            CMD_ALLOC: state_nxt = (limit_in == '0) ? ST_RESP : ST_SCAN;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_RD_WAIT: state_nxt = ST_RESP;
      ST_SCAN: begin
        if (hit || last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_wr    = '0;
    mem_rd    = '0;
    res.valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_cmd == CMD_WRITE)) begin
          mem_wr.en   = addr_ok_in;
          mem_wr.addr = word_in;
          mem_wr.be   = WORD_BYTES'(1) << lane_in;
          mem_wr.data = {WORD_BYTES{in_byte_value}};
        end
        if (in_valid && (in_cmd == CMD_READ)) begin
          mem_rd.en   = addr_ok_in;
          mem_rd.addr = word_in;
        end
      end
      ST_SCAN: begin
        mem_rd.en   = issue;
        mem_rd.addr = issue_ptr_r[WORD_AW-1:0];
        if (hit) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = chk_ptr_r;
          mem_wr.be   = WORD_BYTES'(1) << pos[POS_W-1:3];
          mem_wr.data = rd_data | (WORD_BITS'(1) << pos);
        end
      end
      ST_RESP:    res.valid = out_free;
      ST_RD_WAIT: ;
      default:    ;
    endcase
  end

  assign res.read_byte       = rd_byte_r;
  assign res.allocated_index = aidx_r;
  assign res.map_full        = full_r;

  // Datapath
  always_comb begin
    addr_ok_nxt   = addr_ok_r;
    lane_nxt      = lane_r;
    limit_nxt     = limit_r;
    issue_ptr_nxt = issue_ptr_r;
    chk_ptr_nxt   = chk_ptr_r;
    chk_valid_nxt = 1'b0;
    rd_byte_nxt   = rd_byte_r;
    aidx_nxt      = aidx_r;
    full_nxt      = full_r;
    if (accept) begin
      addr_ok_nxt   = addr_ok_in;
      lane_nxt      = lane_in;
      limit_nxt     = limit_in;
      issue_ptr_nxt = '0;
      rd_byte_nxt   = '0;
      aidx_nxt      = '0;
      full_nxt      = (in_cmd == CMD_ALLOC) && (limit_in == '0);
    end
    if (state_r == ST_RD_WAIT) begin
      rd_byte_nxt = addr_ok_r ? rd_data[{lane_r, 3'b000} +: BYTE_W] : '0;
    end
    if (state_r == ST_SCAN) begin
      chk_valid_nxt = issue;
      if (issue) begin
        chk_ptr_nxt   = issue_ptr_r[WORD_AW-1:0];
        issue_ptr_nxt = issue_ptr_r + LIMIT_W'(1);
      end
      if (hit) begin
        aidx_nxt = AIDX_W'({chk_ptr_r, pos});
      end
      if (last) begin
        full_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_valid_r <= chk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_ok_r   <= addr_ok_nxt;
    lane_r      <= lane_nxt;
    limit_r     <= limit_nxt;
    issue_ptr_r <= issue_ptr_nxt;
    chk_ptr_r   <= chk_ptr_nxt;
    rd_byte_r   <= rd_byte_nxt;
    aidx_r      <= aidx_nxt;
    full_r      <= full_nxt;
  end

endmodule

// ----- rtl/bitmap_first_free_allocator.sv -----
// Write, unused command and allocate with no blocks in use go straight to the result; read
// waits for its registered memory word. Allocate reads 64-bit map words up to the first
// clear bit, at most 128 per block in use (1024 for eight). One command at a time, one
// word per cycle on the single read port while an allocate scans.
// Reset (rst_n, synchronous, active low) clears control state and the block count;
// the bitmap memory is not cleared and must be loaded with write commands before use.
module bitmap_first_free_allocator
  import bfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [12:0] byte_index, [20:13] byte_value, [23:21] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // Result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] read_byte, [23:8] allocated_index
  output logic        out_tuser,  // [0] map_full
  // Block count register
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  logic [CFG_W-1:0]     blocks_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r;
  logic [AIDX_W-1:0]    out_aidx_r;
  logic                 out_full_r;
  logic                 out_free;

  mem_wr_t              mem_wr;
  mem_rd_t              mem_rd;
  logic [WORD_BITS-1:0] rd_data;
  result_t              res;

  // Scan length register: number of map blocks covered by allocate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r <= '0;
    end else if (cfg_wr_en) begin
      blocks_r <= cfg_wr_data;
    end
  end

  // Output register frees the controller once a result is taken in.
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload until taken; load only when a new result arrives.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_byte_r <= res.read_byte;
      out_aidx_r <= res.allocated_index;
      out_full_r <= res.map_full;
    end
  end

  bfa_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_cmd        (in_tuser),
    .in_byte_index (in_tdata[12:0]),
    .in_byte_value (in_tdata[20:13]),
    .blocks_in_use (blocks_r),
    .mem_wr        (mem_wr),
    .mem_rd        (mem_rd),
    .rd_data       (rd_data),
    .out_free      (out_free),
    .res           (res)
  );

  bfa_map_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_aidx_r, out_byte_r};
  assign out_tuser  = out_full_r;

endmodule

// ----- rtl/bfa_checker.sv -----
// Port-level checks for the first-free bitmap allocator, bound to the top level.
// Depends only on the top-level port list.
module bfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Full reports index zero.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[23:8] == 16'd0)
    else $error("full result with nonzero index");

  // A read result carries no allocation.
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] != 8'd0) |-> (out_tdata[23:8] == 16'd0) && !out_tuser)
    else $error("read byte mixed with allocation fields");

  // Take one command at a time: drop ready right after each input transaction.
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a command is in flight");

  // Drop any result across reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bitmap_first_free_allocator bfa_checker u_bfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/sv/bitmap_first_free_allocator_tb.sv -----
// Self-checking testbench for bitmap_first_free_allocator: directed table, then random
// episodes of map loads, reads and first-fit allocations checked against a local predictor.
// Depends on bfa_pkg and the bitmap_first_free_allocator RTL.
module bitmap_first_free_allocator_tb;
  import bfa_pkg::*;

  // Unused command code: the block answers with an all-zero result
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [AIDX_W-1:0] alloc_idx;
    logic              full;
  } bitmap_reply_t;

  typedef struct {
    bit                is_cfg;
    logic [CFG_W-1:0]  count;
    logic [CMD_W-1:0]  cmd;
    logic [BIDX_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    bit                has_literal;
    bitmap_reply_t     literal;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;    // [12:0] byte_index, [20:13] byte_value, [23:21] zero
  logic [1:0]        in_tuser = '0;    // [1:0] cmd
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;        // [7:0] read_byte, [23:8] allocated_index
  logic              out_tuser;        // [0] map_full
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;

  // Predictor state: map image, block count, and which bytes hold defined data
  logic [BYTE_W-1:0] map_image [0:MAP_BYTES-1];
  bit                loaded_flag [0:MAP_BYTES-1];
  logic [CFG_W-1:0]  blocks_in_use = '0;
  int                loaded_upto = 0;   // first byte not yet written, counting from 0
  logic [BIDX_W-1:0] touched_addrs [$];

  bitmap_reply_t     pending_replies [$];
  stim_row_t         directed_rows [$];

  int mismatches = 0;
  int items_sent = 0;
  int replies_seen = 0;
  int sender_idle_pct = 27;
  int receiver_idle_pct = 63;
  int stall_left = 0;
  int stalls_done = 0;
  bit fill_done = 1'b0;

  bitmap_first_free_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Bytes covered by an allocation scan; counts above MAP_BLOCKS saturate
  function automatic int scan_span();
    return ((blocks_in_use > MAP_BLOCKS) ? MAP_BLOCKS : int'(blocks_in_use)) * BLOCK_BYTES;
  endfunction

  // Apply one command to the map image and return the result it produces
  function automatic bitmap_reply_t apply_bitmap_command(input logic [CMD_W-1:0] cmd,
      input logic [BIDX_W-1:0] addr, input logic [BYTE_W-1:0] value);
    bitmap_reply_t r;
    int span;
    r = '0;
    span = scan_span();
    case (cmd)
      CMD_WRITE: begin
        map_image[addr] = value;
        loaded_flag[addr] = 1'b1;
      end
      CMD_READ: r.read_byte = map_image[addr];
      CMD_ALLOC: begin
        // First clear bit, lowest byte first, lowest bit first within a byte
        r.full = 1'b1;
        for (int b = 0; b < span && r.full; b++)
          for (int k = 0; k < 8 && r.full; k++)
            if (!map_image[b][k]) begin
              map_image[b][k] = 1'b1;
              r.alloc_idx = AIDX_W'(b * 8 + k);
              r.full = 1'b0;
            end
      end
      default: ;
    endcase
    return r;
  endfunction

  // True when an allocate would only touch map words that hold defined data
  function automatic bit scan_is_safe();
    int span;
    span = scan_span();
    for (int b = 0; b < span; b++) begin
      if (!loaded_flag[b]) return 1'b0;
      if (map_image[b] != 8'hFF) begin
        for (int k = b; k <= (b | 7); k++)
          if (!loaded_flag[k]) return 1'b0;
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic void add_cmd(input logic [CMD_W-1:0] cmd, input logic [BIDX_W-1:0] addr,
      input logic [BYTE_W-1:0] value, input bit has_literal, input bitmap_reply_t literal);
    stim_row_t row;
    row = '{is_cfg: 1'b0, count: '0, cmd: cmd, addr: addr, value: value,
            has_literal: has_literal, literal: literal};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_W-1:0] count);
    stim_row_t row;
    row = '{is_cfg: 1'b1, count: count, cmd: CMD_NONE, addr: '0, value: '0,
            has_literal: 1'b0, literal: '0};
    directed_rows.push_back(row);
  endfunction

  // Offer one transaction after a random gap; predict its result once accepted
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [BIDX_W-1:0] addr,
      input logic [BYTE_W-1:0] value, input bit has_literal = 1'b0,
      input bitmap_reply_t literal = '0);
    bitmap_reply_t reply;
    bit first_write;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, value, addr};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    first_write = (cmd == CMD_WRITE) && !loaded_flag[addr];
    reply = apply_bitmap_command(cmd, addr, value);
    pending_replies.push_back(has_literal ? literal : reply);
    if (first_write) touched_addrs.push_back(addr);
    while (loaded_upto < MAP_BYTES && loaded_flag[loaded_upto]) loaded_upto++;
    items_sent++;
    // Receiver idles most first, then the sender, then neither
    if (items_sent < 450) begin
      sender_idle_pct = 27;
      receiver_idle_pct = 63;
    end else if (items_sent < 900) begin
      sender_idle_pct = 63;
      receiver_idle_pct = 27;
    end else begin
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
    end
  endtask

  // Drain all outstanding results, then write the block count
  task automatic set_blocks(input logic [CFG_W-1:0] count);
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    blocks_in_use = count;
  endtask

  // Load the next unwritten byte (a random byte once all are written), mostly full so that scans run deep
  task automatic extend_map();
    logic [BYTE_W-1:0] value;
    value = ($urandom_range(15) == 0) ? BYTE_W'($urandom) : 8'hFF;
    if (loaded_upto < MAP_BYTES) send_command(CMD_WRITE, BIDX_W'(loaded_upto), value);
    else send_command(CMD_WRITE, BIDX_W'($urandom), value);
  endtask

  task automatic run_mixed(input int n);
    int pick;
    logic [BIDX_W-1:0] addr;
    repeat (n) begin
      pick = $urandom_range(99);
      addr = touched_addrs[$urandom_range(touched_addrs.size() - 1)];
      if (pick < 15) extend_map();
      else if (pick < 25) send_command(CMD_WRITE, addr, BYTE_W'($urandom));
      else if (pick < 32) send_command(CMD_WRITE, BIDX_W'($urandom), BYTE_W'($urandom));
      else if (pick < 52) send_command(CMD_READ, addr, BYTE_W'($urandom));
      else if (pick < 90) begin
        // Allocate only where the scan stays inside defined map data
        if (scan_is_safe()) send_command(CMD_ALLOC, BIDX_W'($urandom), BYTE_W'($urandom));
        else extend_map();
      end else send_command(CMD_NONE, BIDX_W'($urandom), BYTE_W'($urandom));
    end
  endtask

  // Fill block 0 completely, check the full report, then open one byte again
  task automatic run_fill();
    int spot;
    for (int b = 0; b < BLOCK_BYTES; b++)
      if (map_image[b] != 8'hFF) send_command(CMD_WRITE, BIDX_W'(b), 8'hFF);
    set_blocks(4'd1);
    repeat (3) send_command(CMD_ALLOC, BIDX_W'($urandom), BYTE_W'($urandom));
    spot = $urandom_range(BLOCK_BYTES - 1);
    send_command(CMD_WRITE, BIDX_W'(spot), BYTE_W'($urandom_range(254)));
    repeat (2) send_command(CMD_ALLOC, BIDX_W'($urandom), BYTE_W'($urandom));
    fill_done = 1'b1;
  endtask

  // Result side: check each transaction against the oldest prediction, stall at random
  always @(posedge clk) begin : reply_monitor
    bitmap_reply_t want;
    if (out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: data %h user %b",
                                  out_tdata, out_tuser));
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[7:0] !== want.read_byte)
          report_mismatch($sformatf("read_byte got %h want %h", out_tdata[7:0],
                                    want.read_byte));
        if (out_tdata[23:8] !== want.alloc_idx)
          report_mismatch($sformatf("allocated_index got %0d want %0d", out_tdata[23:8],
                                    want.alloc_idx));
        if (out_tuser !== want.full)
          report_mismatch($sformatf("map_full got %b want %b", out_tuser, want.full));
      end
      replies_seen++;
    end
    // Hold off for a long stretch twice while the sender is offering, so the input stalls
    if (stall_left == 0 && stalls_done < 2 && replies_seen >= 300 * (stalls_done + 1)
        && in_tvalid) begin
      stall_left = 160;
      stalls_done++;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  initial begin
    logic [CFG_W-1:0] count;

    // Directed rows; literal results only where obvious, the rest go through the predictor
    add_cmd(CMD_ALLOC, 13'd0, 8'h00, 1'b1, {8'h00, 16'd0, 1'b1});    // no blocks: full
    add_cmd(CMD_NONE, 13'h1FFF, 8'hFF, 1'b1, '0);
    add_cmd(CMD_WRITE, 13'd0, 8'h00, 1'b1, '0);
    for (int b = 1; b < 8; b++) add_cmd(CMD_WRITE, BIDX_W'(b), 8'hFF, 1'b1, '0);
    add_cmd(CMD_WRITE, 13'h1FFF, 8'hA5, 1'b1, '0);                   // top of the map
    add_cmd(CMD_READ, 13'h1FFF, 8'h00, 1'b1, {8'hA5, 16'd0, 1'b0});
    add_cmd(CMD_WRITE, 13'h1555, 8'h5A, 1'b1, '0);
    add_cmd(CMD_READ, 13'h1555, 8'hFF, 1'b1, {8'h5A, 16'd0, 1'b0});
    add_cfg(4'd1);
    add_cmd(CMD_ALLOC, 13'd0, 8'h00, 1'b1, {8'h00, 16'd0, 1'b0});    // index zero, not full
    add_cmd(CMD_ALLOC, 13'd0, 8'h00, 1'b1, {8'h00, 16'd1, 1'b0});
    add_cmd(CMD_READ, 13'd0, 8'h00, 1'b1, {8'h03, 16'd0, 1'b0});
    add_cmd(CMD_WRITE, 13'd0, 8'h7F, 1'b1, '0);
    add_cmd(CMD_ALLOC, 13'd0, 8'h00, 1'b1, {8'h00, 16'd7, 1'b0});
    add_cfg(4'd15);                                                  // saturates to all blocks
    add_cmd(CMD_WRITE, 13'd3, 8'hEF, 1'b0, '0);
    add_cmd(CMD_ALLOC, 13'h1FFF, 8'hFF, 1'b0, '0);
    add_cmd(CMD_READ, 13'd3, 8'h00, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) set_blocks(directed_rows[i].count);
      else send_command(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].value,
                        directed_rows[i].has_literal, directed_rows[i].literal);
    end

    // Random episodes, each under a fresh block count; extremes come up often
    while (items_sent < 1300 || !fill_done) begin
      case ($urandom_range(9))
        0: count = 4'd0;
        1: count = 4'd8;
        2: count = 4'd15;
        3: count = 4'd1;
        default: count = CFG_W'($urandom_range(15));
      endcase
      set_blocks(count);
      if (loaded_upto < BLOCK_BYTES + 8 && $urandom_range(1) == 1) begin
        repeat ($urandom_range(64, 128)) extend_map();
      end else if (loaded_upto >= BLOCK_BYTES + 8 && !fill_done) begin
        run_fill();
      end else begin
        run_mixed($urandom_range(20, 50));
      end
    end

    // Drop valid, drain, then give stray results time to show up
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
